### rtl/core/lrd_pkg.sv
// ---------------------------------------------------------------------------
// lrd_pkg
// Shared types, register indexes, effect codes and small arithmetic helpers
// of the LED pixel effect renderer.
// ---------------------------------------------------------------------------
package lrd_pkg;

	localparam int DivBits   = 52;
	localparam int DivStep   = 4;
	localparam int DivStages = DivBits / DivStep;

	localparam logic [2:0] REG_MODE     = 3'd0;
	localparam logic [2:0] REG_COLOR    = 3'd1;
	localparam logic [2:0] REG_BRIGHT   = 3'd2;
	localparam logic [2:0] REG_SPEED    = 3'd3;
	localparam logic [2:0] REG_PROGRESS = 3'd4;
	localparam logic [2:0] REG_AUDIO    = 3'd5;

	localparam logic [3:0] FX_SOLID    = 4'd0;
	localparam logic [3:0] FX_BREATHE  = 4'd1;
	localparam logic [3:0] FX_STROBE   = 4'd2;
	localparam logic [3:0] FX_CYCLE    = 4'd3;
	localparam logic [3:0] FX_RAINBOW  = 4'd4;
	localparam logic [3:0] FX_FLOW     = 4'd5;
	localparam logic [3:0] FX_WAVE     = 4'd6;
	localparam logic [3:0] FX_MARQUEE  = 4'd7;
	localparam logic [3:0] FX_CYLON    = 4'd8;
	localparam logic [3:0] FX_PROGRESS = 4'd9;
	localparam logic [3:0] FX_AUDIO    = 4'd10;

	typedef struct packed {
		logic [3:0]         mode;
		logic [23:0]        color;
		logic [7:0]         bright;
		logic [7:0]         speed;
		logic signed [17:0] progress;
		logic [16:0]        audio;
	} cfg_t;

	typedef struct packed {
		logic [3:0]  mode;
		logic [15:0] pos;
		logic [15:0] len;
		logic [16:0] span;
		logic [7:0]  wfold;
		logic        strobe;
		logic        marq;
		logic        plit;
		logic        alit;
		logic [15:0] hbase;
	} meta_t;

	// x / 255 for x up to 255 * 255
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [31:0] p;
		p = 32'(x) * 32'h0000_8081;
		return p[30:23];
	endfunction

	function automatic logic [7:0] flow_lvl(input logic [2:0] d);
		logic [7:0] l;
		case (d)
			3'd0:    l = 8'd255;
			3'd1:    l = 8'd212;
			3'd2:    l = 8'd170;
			3'd3:    l = 8'd127;
			3'd4:    l = 8'd85;
			3'd5:    l = 8'd42;
			default: l = 8'd0;
		endcase
		return l;
	endfunction

	function automatic logic [7:0] cylon_lvl(input logic [2:0] d);
		logic [7:0] l;
		case (d)
			3'd0:    l = 8'd255;
			3'd1:    l = 8'd204;
			3'd2:    l = 8'd153;
			3'd3:    l = 8'd102;
			3'd4:    l = 8'd51;
			default: l = 8'd0;
		endcase
		return l;
	endfunction

endpackage

### rtl/core/lrd_front.sv
// ---------------------------------------------------------------------------
// lrd_front
// Phase, per-effect flags and divider operands (stages s1 to s3).
// ---------------------------------------------------------------------------
module lrd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [63:0]        in_data,
	input  lrd_pkg::cfg_t      cfg,
	output logic               out_valid,
	output logic [51:0]        out_num,
	output logic [16:0]        out_den,
	output lrd_pkg::meta_t     out_meta
);
	import lrd_pkg::*;

	logic        v_s1, v_s2, v_s3;
	logic [15:0] pos_s1, len_s1;
	logic [31:0] phase_s1;
	meta_t       meta_s2, meta_s3;
	logic [29:0] ph6_s2;
	logic [28:0] ph8_s2;
	logic [51:0] num_s3;
	logic [16:0] den_s3;

	logic [35:0] phase_full;
	logic [15:0] len_in;
	logic [63:0] p6;
	logic [28:0] my;
	logic [63:0] m3;
	logic [30:0] q3;
	logic [28:0] r3;
	logic [16:0] pf, af;
	logic [32:0] pc, ac;
	logic [8:0]  wp;
	logic [51:0] flow_num;

	assign len_in     = (in_data[31:16] == 16'd0) ? 16'd1 : in_data[31:16];
	assign phase_full = 36'(in_data[63:32]) * 36'({1'b0, cfg.speed[7:5]} + 4'd1);

	assign p6 = 64'(phase_s1) * 64'h0000_0000_AAAA_AAAB;
	assign my = 29'(pos_s1) + 29'(phase_s1[31:4]);
	assign m3 = 64'(my) * 64'h0000_0000_AAAA_AAAB;
	assign q3 = m3[63:33];
	assign r3 = my - (29'(q3) + {28'(q3), 1'b0});
	assign pf = cfg.progress[17] ? 17'd0 :
		((cfg.progress[16:0] > 17'd65536) ? 17'd65536 : cfg.progress[16:0]);
	assign af = (cfg.audio > 17'd65536) ? 17'd65536 : cfg.audio;
	assign pc = 33'(pf) * 33'(len_s1);
	assign ac = 33'(af) * 33'(len_s1) + 33'd65470;
	assign wp = phase_s1[8:0];

	assign flow_num = {4'd0, meta_s2.len, 32'd0} + 52'(meta_s2.pos) - 52'(ph6_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s1   <= in_data[15:0];
			len_s1   <= len_in;
			phase_s1 <= phase_full[31:0];

			meta_s2.mode   <= cfg.mode;
			meta_s2.pos    <= pos_s1;
			meta_s2.len    <= len_s1;
			meta_s2.span   <= (len_s1 > 16'd1) ? ({1'b0, len_s1} << 1) - 17'd2 : 17'd1;
			meta_s2.wfold  <= wp[8] ? ~wp[7:0] : wp[7:0];
			meta_s2.strobe <= phase_s1[6];
			meta_s2.marq   <= (r3[1:0] == 2'd0);
			meta_s2.plit   <= (33'(pos_s1) < 33'(pc[32:16]));
			meta_s2.alit   <= (33'(pos_s1) < 33'(ac[32:16]));
			meta_s2.hbase  <= {phase_s1[8:0], 7'd0};
			ph6_s2         <= p6[63:34];
			ph8_s2         <= phase_s1[31:3];

			meta_s3 <= meta_s2;
			case (meta_s2.mode)
				FX_RAINBOW, FX_WAVE: begin
					num_s3 <= 52'd65536;
					den_s3 <= {1'b0, meta_s2.len};
				end
				FX_FLOW: begin
					num_s3 <= flow_num;
					den_s3 <= {1'b0, meta_s2.len};
				end
				FX_CYLON: begin
					num_s3 <= 52'(ph8_s2);
					den_s3 <= meta_s2.span;
				end
				default: begin
					num_s3 <= 52'd0;
					den_s3 <= 17'd1;
				end
			endcase
		end
	end

	assign out_valid = v_s3;
	assign out_num   = num_s3;
	assign out_den   = den_s3;
	assign out_meta  = meta_s3;

endmodule

### rtl/core/lrd_div.sv
// ---------------------------------------------------------------------------
// lrd_div
// Pipelined restoring divider, four quotient bits per stage (s4 to s16).
// ---------------------------------------------------------------------------
module lrd_div (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  logic [51:0]    in_num,
	input  logic [16:0]    in_den,
	input  lrd_pkg::meta_t in_meta,
	output logic           out_valid,
	output logic [16:0]    out_quo,
	output logic [16:0]    out_rem,
	output lrd_pkg::meta_t out_meta
);
	import lrd_pkg::*;

	logic        v_sx    [DivStages];
	logic [51:0] num_sx  [DivStages];
	logic [16:0] den_sx  [DivStages];
	logic [16:0] rem_sx  [DivStages];
	logic [16:0] quo_sx  [DivStages];
	meta_t       meta_sx [DivStages];

	logic [51:0] src_num [DivStages];
	logic [16:0] src_den [DivStages];
	logic [16:0] src_rem [DivStages];
	logic [16:0] src_quo [DivStages];
	logic [16:0] nx_rem  [DivStages];
	logic [16:0] nx_quo  [DivStages];

	always_comb begin
		src_num[0] = in_num;
		src_den[0] = in_den;
		src_rem[0] = 17'd0;
		src_quo[0] = 17'd0;
		for (int k = 1; k < DivStages; k++) begin
			src_num[k] = num_sx[k-1];
			src_den[k] = den_sx[k-1];
			src_rem[k] = rem_sx[k-1];
			src_quo[k] = quo_sx[k-1];
		end
		for (int k = 0; k < DivStages; k++) begin
			logic [17:0] t;
			logic [16:0] r;
			logic [16:0] q;
			r = src_rem[k];
			q = src_quo[k];
			for (int b = 0; b < DivStep; b++) begin
				t = {r, src_num[k][DivBits-1-b]};
				if (t >= {1'b0, src_den[k]}) begin
					r = 17'(t - {1'b0, src_den[k]});
					q = {q[15:0], 1'b1};
				end else begin
					r = t[16:0];
					q = {q[15:0], 1'b0};
				end
			end
			nx_rem[k] = r;
			nx_quo[k] = q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DivStages; k++) v_sx[k] <= 1'b0;
		end else if (en) begin
			v_sx[0] <= in_valid;
			for (int k = 1; k < DivStages; k++) v_sx[k] <= v_sx[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_sx[0] <= in_meta;
			for (int k = 1; k < DivStages; k++) meta_sx[k] <= meta_sx[k-1];
			for (int k = 0; k < DivStages; k++) begin
				num_sx[k]  <= src_num[k] << DivStep;
				den_sx[k]  <= src_den[k];
				rem_sx[k]  <= nx_rem[k];
				quo_sx[k]  <= nx_quo[k];
			end
		end
	end

	assign out_valid = v_sx[DivStages-1];
	assign out_quo   = quo_sx[DivStages-1];
	assign out_rem   = rem_sx[DivStages-1];
	assign out_meta  = meta_sx[DivStages-1];

endmodule

### rtl/core/lrd_back.sv
// ---------------------------------------------------------------------------
// lrd_back
// Level, hue to color and drive scaling (stages s17 to s21).
// ---------------------------------------------------------------------------
module lrd_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  logic [16:0]    in_quo,
	input  logic [16:0]    in_rem,
	input  lrd_pkg::meta_t in_meta,
	input  lrd_pkg::cfg_t  cfg,
	output logic           out_valid,
	output logic [55:0]    out_data
);
	import lrd_pkg::*;

	logic        v_s17, v_s18, v_s19, v_s20, v_s21;
	meta_t       meta_s17;
	logic [15:0] prod_s17, bw_s17;
	logic [16:0] head_s17, rem_s17;
	logic [15:0] hue_s18;
	logic [7:0]  raw_s18;
	logic        scl_s18, usehue_s18, dark_s18;
	logic [2:0]  reg_s19;
	logic [15:0] rem6_s19;
	logic [7:0]  lvl_s19, lvl_s20;
	logic        usehue_s19, dark_s19;
	logic [23:0] rgb_s20;
	logic [55:0] out_s21;

	logic [16:0] af;
	logic [32:0] ahue;
	logic [15:0] x;
	logic [16:0] cd;
	logic [3:0]  m;
	logic [15:0] hb;
	logic [2:0]  rg;
	logic [31:0] tm;
	logic [7:0]  t, q;

	assign af   = (cfg.audio > 17'd65536) ? 17'd65536 : cfg.audio;
	assign ahue = 33'(17'd65536 - af) * 33'd43690;
	assign m    = meta_s17.mode;
	assign x    = meta_s17.hbase + prod_s17;
	assign cd   = ({1'b0, meta_s17.pos} > head_s17) ?
		{1'b0, meta_s17.pos} - head_s17 : head_s17 - {1'b0, meta_s17.pos};

	always_comb begin
		if (hue_s18 < 16'd10923)      rg = 3'd0;
		else if (hue_s18 < 16'd21846) rg = 3'd1;
		else if (hue_s18 < 16'd32769) rg = 3'd2;
		else if (hue_s18 < 16'd43692) rg = 3'd3;
		else if (hue_s18 < 16'd54615) rg = 3'd4;
		else                          rg = 3'd5;
		case (rg)
			3'd0:    hb = 16'd0;
			3'd1:    hb = 16'd10923;
			3'd2:    hb = 16'd21846;
			3'd3:    hb = 16'd32769;
			3'd4:    hb = 16'd43692;
			default: hb = 16'd54615;
		endcase
	end

	assign tm = 32'(rem6_s19) * 32'd65281;
	assign t  = tm[31:24];
	assign q  = 8'd255 - t;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s17 <= 1'b0;
			v_s18 <= 1'b0;
			v_s19 <= 1'b0;
			v_s20 <= 1'b0;
			v_s21 <= 1'b0;
		end else if (en) begin
			v_s17 <= in_valid;
			v_s18 <= v_s17;
			v_s19 <= v_s18;
			v_s20 <= v_s19;
			v_s21 <= v_s20;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s17 <= in_meta;
			prod_s17 <= 16'(in_meta.pos * in_quo[15:0]);
			bw_s17   <= 16'(in_meta.wfold) * 16'd215;
			rem_s17  <= in_rem;
			head_s17 <= (in_rem < {1'b0, in_meta.len}) ? in_rem : in_meta.span - in_rem;

			usehue_s18 <= (m == FX_CYCLE) || (m == FX_RAINBOW) || (m == FX_AUDIO);
			dark_s18   <= (m == FX_PROGRESS) && !meta_s17.plit;
			scl_s18    <= (m == FX_BREATHE) || (m == FX_FLOW) || (m == FX_WAVE) ||
				(m == FX_CYLON);
			hue_s18    <= (m == FX_CYCLE) ? meta_s17.hbase :
				((m == FX_AUDIO) ? ahue[31:16] : x);
			case (m)
				FX_BREATHE:  raw_s18 <= 8'd40 + div255(bw_s17);
				FX_STROBE:   raw_s18 <= meta_s17.strobe ? 8'd0 : cfg.bright;
				FX_FLOW:     raw_s18 <= (rem_s17 < 17'd6) ? flow_lvl(rem_s17[2:0]) : 8'd0;
				FX_WAVE:     raw_s18 <= x[15] ? ~x[14:7] : x[14:7];
				FX_MARQUEE:  raw_s18 <= meta_s17.marq ? cfg.bright : 8'd0;
				FX_CYLON:    raw_s18 <= (cd < 17'd5) ? cylon_lvl(cd[2:0]) : 8'd0;
				FX_PROGRESS: raw_s18 <= meta_s17.plit ? cfg.bright : 8'd255;
				FX_AUDIO:    raw_s18 <= meta_s17.alit ? cfg.bright : 8'd0;
				default:     raw_s18 <= cfg.bright;
			endcase

			reg_s19    <= rg;
			rem6_s19   <= 16'((hue_s18 - hb) * 16'd6);
			lvl_s19    <= scl_s18 ? div255(16'(cfg.bright) * 16'(raw_s18)) : raw_s18;
			usehue_s19 <= usehue_s18;
			dark_s19   <= dark_s18;

			lvl_s20 <= lvl_s19;
			if (dark_s19) begin
				rgb_s20 <= 24'd0;
			end else if (usehue_s19) begin
				case (reg_s19)
					3'd0:    rgb_s20 <= {8'd255, t, 8'd0};
					3'd1:    rgb_s20 <= {q, 8'd255, 8'd0};
					3'd2:    rgb_s20 <= {8'd0, 8'd255, t};
					3'd3:    rgb_s20 <= {8'd0, q, 8'd255};
					3'd4:    rgb_s20 <= {t, 8'd0, 8'd255};
					default: rgb_s20 <= {8'd255, 8'd0, q};
				endcase
			end else begin
				rgb_s20 <= cfg.color;
			end

			out_s21 <= {div255(16'(rgb_s20[7:0]) * 16'(lvl_s20)),
				div255(16'(rgb_s20[15:8]) * 16'(lvl_s20)),
				div255(16'(rgb_s20[23:16]) * 16'(lvl_s20)),
				lvl_s20, rgb_s20[7:0], rgb_s20[15:8], rgb_s20[23:16]};
		end
	end

	assign out_valid = v_s21;
	assign out_data  = out_s21;

endmodule

### rtl/core/led_pixel_effect_renderer_core.sv
// ---------------------------------------------------------------------------
// led_pixel_effect_renderer_core
// Renders one pixel of the configured LED effect per input word.
//
// The s_ side takes one word per pixel: position, strip length and frame
// tick. The m_ side returns, per pixel, the effect color, its level and the
// color scaled by that level, in input order. The cfg_ side writes the six
// effect registers; it is always ready; the user must see that it is written
// only while idle; the block itself does not enforce this. A new word can
// enter every cycle unless the receiver stalls; the rate is one pixel per
// cycle, set by the 21-stage pipeline around a 13-stage pipelined divider
// (four quotient bits per stage) that serves the rainbow and wave step, the
// flow head and the scanner travel. When the receiver stalls, the whole
// pipeline holds and s_tready drops; no word is lost or repeated. Reset
// empties the pipeline and loads the register defaults: solid mode, black,
// full brightness, speed zero, progress negative, audio zero.
// ---------------------------------------------------------------------------
module led_pixel_effect_renderer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // pixel_position, strip_length, frame_tick
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // color_red, color_green, color_blue, intensity,
	                               // drive_red, drive_green, drive_blue
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data
);
	import lrd_pkg::*;

	cfg_t        cfg_q;
	logic        en;
	logic        f_valid, d_valid;
	logic [51:0] f_num;
	logic [16:0] f_den, d_quo, d_rem;
	meta_t       f_meta, d_meta;

	assign cfg_ready = 1'b1;
	assign en        = !m_tvalid || m_tready;
	assign s_tready  = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode     <= FX_SOLID;
			cfg_q.color    <= 24'd0;
			cfg_q.bright   <= 8'd255;
			cfg_q.speed    <= 8'd0;
			cfg_q.progress <= -18'sd65536;
			cfg_q.audio    <= 17'd0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MODE:     cfg_q.mode     <= cfg_data[3:0];
				REG_COLOR:    cfg_q.color    <= cfg_data;
				REG_BRIGHT:   cfg_q.bright   <= cfg_data[7:0];
				REG_SPEED:    cfg_q.speed    <= cfg_data[7:0];
				REG_PROGRESS: cfg_q.progress <= cfg_data[17:0];
				REG_AUDIO:    cfg_q.audio    <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	lrd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid && en),
		.in_data   (s_tdata),
		.cfg       (cfg_q),
		.out_valid (f_valid),
		.out_num   (f_num),
		.out_den   (f_den),
		.out_meta  (f_meta)
	);

	lrd_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (f_valid),
		.in_num    (f_num),
		.in_den    (f_den),
		.in_meta   (f_meta),
		.out_valid (d_valid),
		.out_quo   (d_quo),
		.out_rem   (d_rem),
		.out_meta  (d_meta)
	);

	lrd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (d_valid),
		.in_quo    (d_quo),
		.in_rem    (d_rem),
		.in_meta   (d_meta),
		.cfg       (cfg_q),
		.out_valid (m_tvalid),
		.out_data  (m_tdata)
	);

	a_full_level: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[31:24] == 8'd255 |->
			m_tdata[39:32] == m_tdata[7:0] && m_tdata[47:40] == m_tdata[15:8] &&
			m_tdata[55:48] == m_tdata[23:16])
		else $error("full level drive differs from color");

	a_zero_level: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[31:24] == 8'd0 |-> m_tdata[55:32] == 24'd0)
		else $error("zero level gives nonzero drive");

	a_drive_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[39:32] <= m_tdata[7:0] &&
			m_tdata[47:40] <= m_tdata[15:8] && m_tdata[55:48] <= m_tdata[23:16])
		else $error("drive exceeds color");

endmodule
